[rtl/prpid_pkg.sv]
// Shared constants, register codes and types of the pitch/roll PID controller.
`default_nettype none

package prpid_pkg;

	// Field widths
	localparam int PULSE_W    = 12;
	localparam int MEAS_W     = 17;
	localparam int GAIN_W     = 16;
	localparam int LIMIT_W    = 15;
	localparam int DRIVE_W    = 16;
	localparam int INTEG_W    = 25;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Default radio range and per-axis maximum angle in degrees
	localparam int RADIO_LOW_DEF       = 1000;
	localparam int RADIO_HIGH_DEF      = 1956;
	localparam int PITCH_MAX_ANGLE_DEF = 30;
	localparam int ROLL_MAX_ANGLE_DEF  = 30;

	// Stick dead band around center
	localparam logic [PULSE_W-1:0] SNAP_LO  = PULSE_W'(1460);
	localparam logic [PULSE_W-1:0] SNAP_HI  = PULSE_W'(1500);
	localparam logic [PULSE_W-1:0] SNAP_CTR = PULSE_W'(1478);

	// Angle mapping: full stick travel covers 90 degrees, centered on zero
	localparam int FULL_RANGE_DEG = 90;
	localparam int HALF_RANGE_DEG = 45;

	// Q8.8 scaling
	localparam int Q_SHIFT   = 8;
	localparam int Q_SCALE   = 256;
	localparam longint MEAS_FULL   = 65536;   // largest magnitude of a Q8.8 measurement
	localparam int MEAS_DEG_MAX    = 256;     // that magnitude in whole degrees

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Command codes
	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_KP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_KI_DT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_KD_DT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROLL_KP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROLL_KI_DT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROLL_KD_DT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_LIMIT = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ROLL_LIMIT  = 3'd7;

	// Gains and bound of one axis
	typedef struct packed {
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki;
		logic signed [GAIN_W-1:0] kd;
		logic [LIMIT_W-1:0]       limit;
	} axis_cfg_t;

endpackage

`default_nettype wire

[rtl/prpid_if.sv]
// Channel interfaces: update items in, drive results out, register writes.
`default_nettype none

interface prpid_update_if;
	import prpid_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     command;
	logic [PULSE_W-1:0]       roll_pulse;
	logic [PULSE_W-1:0]       pitch_pulse;
	logic signed [MEAS_W-1:0] measured_pitch;
	logic signed [MEAS_W-1:0] measured_roll;

	modport source (output valid, command, roll_pulse, pitch_pulse, measured_pitch,
		measured_roll, input ready);
	modport sink (input valid, command, roll_pulse, pitch_pulse, measured_pitch,
		measured_roll, output ready);
endinterface

interface prpid_drive_if;
	import prpid_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] pitch_drive;
	logic signed [DRIVE_W-1:0] roll_drive;

	modport source (output valid, pitch_drive, roll_drive, input ready);
	modport sink (input valid, pitch_drive, roll_drive, output ready);
endinterface

interface prpid_cfg_if;
	import prpid_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/prpid_axis_err.sv]
// Pulse to target angle and whole-degree error of one axis, stages 2 to 6.
`default_nettype none

module prpid_axis_err #(
	parameter int RADIO_LOW  = prpid_pkg::RADIO_LOW_DEF,
	parameter int RADIO_HIGH = prpid_pkg::RADIO_HIGH_DEF,
	parameter int MAX_ANGLE  = prpid_pkg::PITCH_MAX_ANGLE_DEF,
	parameter int ERR_W      = 10
) (
	input  wire logic                               clk,
	input  wire logic                               en,
	input  wire logic [prpid_pkg::PULSE_W-1:0]      pulse_s1,
	input  wire logic signed [prpid_pkg::MEAS_W-1:0] meas_s1,
	output logic signed [ERR_W-1:0]                 err_s6
);
	import prpid_pkg::*;

	// error = (meas*SPAN - 256*num) / (256*SPAN), num = target*SPAN
	localparam longint SPAN  = longint'(RADIO_HIGH - RADIO_LOW);
	localparam longint DIV   = longint'(Q_SCALE) * SPAN;
	localparam longint XMAX  = SPAN * (MEAS_FULL + longint'(Q_SCALE * MAX_ANGLE));
	localparam int     XW    = $clog2(XMAX + 1);
	localparam longint RECIP = (longint'(1) << XW) / DIV;
	localparam int     MW    = $clog2(RECIP + 1);
	localparam int     QW    = $clog2(MEAS_DEG_MAX + MAX_ANGLE + 1);
	localparam int     OFFW  = $clog2(SPAN + 1);
	localparam int     NUMW  = $clog2(longint'(HALF_RANGE_DEG) * SPAN + 1) + 1;

	localparam logic [PULSE_W-1:0]     LOW_P    = PULSE_W'(RADIO_LOW);
	localparam logic [PULSE_W-1:0]     HIGH_P   = PULSE_W'(RADIO_HIGH);
	localparam logic [NUMW-1:0]        FULL_N   = NUMW'(FULL_RANGE_DEG);
	localparam logic [NUMW-1:0]        BIAS_N   = NUMW'(longint'(HALF_RANGE_DEG) * SPAN);
	localparam logic signed [NUMW-1:0] NUM_HI   = NUMW'(longint'(MAX_ANGLE) * SPAN);
	localparam logic signed [NUMW-1:0] NUM_LO   = -NUM_HI;
	localparam logic signed [XW:0]     SPAN_X   = (XW+1)'(SPAN);
	localparam logic [MW-1:0]          RECIP_V  = MW'(RECIP);
	localparam logic [XW-1:0]          DIV_V    = XW'(DIV);

	// stage 2: dead band, range clamp, target numerator, scaled measurement
	logic [PULSE_W-1:0]     p_snap;
	logic [PULSE_W-1:0]     p_clamp;
	logic [OFFW-1:0]        off;
	logic signed [NUMW-1:0] num_raw;
	logic signed [NUMW-1:0] num_clamp;
	logic signed [XW:0]     meas_x;
	logic signed [XW:0]     mspan;
	logic signed [NUMW-1:0] num_s2;
	logic signed [XW:0]     mspan_s2;

	always_comb begin
		p_snap = (pulse_s1 > SNAP_LO && pulse_s1 < SNAP_HI) ? SNAP_CTR : pulse_s1;
		priority if (p_snap < LOW_P) begin
			p_clamp = LOW_P;
		end else if (p_snap > HIGH_P) begin
			p_clamp = HIGH_P;
		end else begin
			p_clamp = p_snap;
		end
		off     = OFFW'(p_clamp - LOW_P);
		num_raw = $signed(NUMW'(off) * FULL_N - BIAS_N);
		priority if (num_raw > NUM_HI) begin
			num_clamp = NUM_HI;
		end else if (num_raw < NUM_LO) begin
			num_clamp = NUM_LO;
		end else begin
			num_clamp = num_raw;
		end
		meas_x = (XW+1)'(meas_s1);
		mspan  = meas_x * SPAN_X;
	end

	// stage 3: signed numerator of the quotient, split into sign and magnitude
	logic signed [XW:0] num_x;
	logic signed [XW:0] xnum;
	logic               neg_s3;
	logic [XW-1:0]      mag_s3;

	always_comb begin
		num_x = (XW+1)'(num_s2);
		xnum  = mspan_s2 - (num_x <<< Q_SHIFT);
	end

	// stage 4: reciprocal estimate, low by at most one
	logic [XW+MW-1:0] prod;
	logic [QW-1:0]    qe_s4;
	logic [XW-1:0]    mag_s4;
	logic             neg_s4;

	assign prod = (XW+MW)'(mag_s3) * (XW+MW)'(RECIP_V);

	// stage 5: estimate times divisor
	logic [XW-1:0] back_s5;
	logic [QW-1:0] qe_s5;
	logic [XW-1:0] mag_s5;
	logic          neg_s5;

	// stage 6: correct by one and apply the sign
	logic [XW-1:0]           rem;
	logic [QW-1:0]           q_fix;
	logic signed [ERR_W-1:0] q_ext;

	always_comb begin
		rem   = mag_s5 - back_s5;
		q_fix = qe_s5 + QW'(rem >= DIV_V);
		q_ext = ERR_W'(q_fix);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2   <= num_clamp;
			mspan_s2 <= mspan;
			neg_s3   <= xnum[XW];
			mag_s3   <= XW'(xnum[XW] ? -xnum : xnum);
			qe_s4    <= prod[XW +: QW];
			mag_s4   <= mag_s3;
			neg_s4   <= neg_s3;
			back_s5  <= XW'(qe_s4) * DIV_V;
			qe_s5    <= qe_s4;
			mag_s5   <= mag_s4;
			neg_s5   <= neg_s4;
			err_s6   <= neg_s5 ? -q_ext : q_ext;
		end
	end

endmodule

`default_nettype wire

[rtl/prpid_front.sv]
// Front end: accepts update items and computes both axis errors in a stalling pipeline.
`default_nettype none

module prpid_front #(
	parameter int RADIO_LOW       = prpid_pkg::RADIO_LOW_DEF,
	parameter int RADIO_HIGH      = prpid_pkg::RADIO_HIGH_DEF,
	parameter int PITCH_MAX_ANGLE = prpid_pkg::PITCH_MAX_ANGLE_DEF,
	parameter int ROLL_MAX_ANGLE  = prpid_pkg::ROLL_MAX_ANGLE_DEF,
	parameter int ERR_W           = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	prpid_update_if.sink            update,
	input  wire logic               full,
	output logic                    push,
	output logic                    cmd_s6,
	output logic signed [ERR_W-1:0] err_pitch_s6,
	output logic signed [ERR_W-1:0] err_roll_s6
);
	import prpid_pkg::*;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5;
	logic [PULSE_W-1:0]       pitch_pulse_s1;
	logic [PULSE_W-1:0]       roll_pulse_s1;
	logic signed [MEAS_W-1:0] meas_pitch_s1;
	logic signed [MEAS_W-1:0] meas_roll_s1;

	// whole pipe moves unless the last stage holds an item the queue cannot take
	assign adv          = !v_s6 || !full;
	assign push         = v_s6 && !full;
	assign update.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= update.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// input capture and command tag
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1         <= update.command;
			pitch_pulse_s1 <= update.pitch_pulse;
			roll_pulse_s1  <= update.roll_pulse;
			meas_pitch_s1  <= update.measured_pitch;
			meas_roll_s1   <= update.measured_roll;
			cmd_s2         <= cmd_s1;
			cmd_s3         <= cmd_s2;
			cmd_s4         <= cmd_s3;
			cmd_s5         <= cmd_s4;
			cmd_s6         <= cmd_s5;
		end
	end

	prpid_axis_err #(
		.RADIO_LOW  (RADIO_LOW),
		.RADIO_HIGH (RADIO_HIGH),
		.MAX_ANGLE  (PITCH_MAX_ANGLE),
		.ERR_W      (ERR_W)
	) u_pitch_err (
		.clk      (clk),
		.en       (adv),
		.pulse_s1 (pitch_pulse_s1),
		.meas_s1  (meas_pitch_s1),
		.err_s6   (err_pitch_s6)
	);

	prpid_axis_err #(
		.RADIO_LOW  (RADIO_LOW),
		.RADIO_HIGH (RADIO_HIGH),
		.MAX_ANGLE  (ROLL_MAX_ANGLE),
		.ERR_W      (ERR_W)
	) u_roll_err (
		.clk      (clk),
		.en       (adv),
		.pulse_s1 (roll_pulse_s1),
		.meas_s1  (meas_roll_s1),
		.err_s6   (err_roll_s6)
	);

endmodule

`default_nettype wire

[rtl/prpid_queue.sv]
// Short first-word-fall-through queue between the front and the back.
`default_nettype none

module prpid_queue #(
	parameter int W     = 21,
	parameter int DEPTH = prpid_pkg::QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         pop,
	output logic              empty,
	output logic [W-1:0]      rdata
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	// pointers wrap at DEPTH
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/prpid_back.sv]
// Back end: PID of both axes with saturating integrators, feeding the output register.
`default_nettype none

module prpid_back #(
	parameter int ERR_W = 10
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire prpid_pkg::axis_cfg_t  pitch_cfg,
	input  wire prpid_pkg::axis_cfg_t  roll_cfg,
	input  wire logic                  empty,
	input  wire logic [2*ERR_W:0]      rdata,
	output logic                       pop,
	prpid_drive_if.source              drive
);
	import prpid_pkg::*;

	localparam int PW   = ERR_W + GAIN_W;
	localparam int ACCW = ((PW > INTEG_W) ? PW : INTEG_W) + 1;
	localparam int SUMW = ((PW + 2 > INTEG_W) ? PW + 2 : INTEG_W) + 1;

	logic      adv;
	logic      v_b1, v_b2, v_b3, v_b4;
	logic      cmd_b1, cmd_b2, cmd_b3;
	axis_cfg_t acfg [2];
	logic signed [ERR_W-1:0]   err_in [2];
	logic signed [DRIVE_W-1:0] drv [2];

	assign acfg[0]   = pitch_cfg;
	assign acfg[1]   = roll_cfg;
	assign err_in[0] = rdata[2*ERR_W-1:ERR_W];
	assign err_in[1] = rdata[ERR_W-1:0];

	// back pipe moves while the output register is free or being taken
	assign adv         = !v_b4 || drive.ready;
	assign pop         = adv && !empty;
	assign drive.valid = v_b4;
	assign drive.pitch_drive = drv[0];
	assign drive.roll_drive  = drv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
			v_b4 <= 1'b0;
		end else if (adv) begin
			v_b1 <= !empty;
			v_b2 <= v_b1;
			v_b3 <= v_b2;
			v_b4 <= v_b3 && (cmd_b3 == CMD_UPDATE);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_b1 <= rdata[2*ERR_W];
			cmd_b2 <= cmd_b1;
			cmd_b3 <= cmd_b2;
		end
	end

	for (genvar a = 0; a < 2; a++) begin : g_axis
		logic signed [ERR_W-1:0]   err_b1;
		logic signed [ERR_W-1:0]   last_q;
		logic signed [ERR_W:0]     diff;
		logic signed [PW-1:0]      pi_b2;
		logic signed [PW-1:0]      pp_b2;
		logic signed [PW:0]        pd_b2;
		logic signed [PW+1:0]      ppd_b3;
		logic signed [ACCW-1:0]    acc;
		logic signed [ACCW-1:0]    bound;
		logic signed [ACCW-1:0]    acc_sat;
		logic signed [INTEG_W-1:0] integ_q;
		logic signed [SUMW-1:0]    sum;
		logic signed [SUMW-1:0]    rnd;
		logic signed [SUMW-1:0]    tq;
		logic signed [SUMW-1:0]    lim;
		logic signed [SUMW-1:0]    sat;
		logic signed [DRIVE_W-1:0] drive_b4;

		// b2 operands: derivative against the last error
		assign diff = (ERR_W+1)'(err_b1) - (ERR_W+1)'(last_q);

		// b3: integrator step, clamped to the symmetric bound
		always_comb begin
			acc   = ACCW'(integ_q) + ACCW'(pi_b2);
			bound = $signed(ACCW'({acfg[a].limit, {Q_SHIFT{1'b0}}}));
			priority if (acc > bound) begin
				acc_sat = bound;
			end else if (acc < -bound) begin
				acc_sat = -bound;
			end else begin
				acc_sat = acc;
			end
		end

		// b4: full sum, truncate toward zero to whole units, clamp to the limit
		always_comb begin
			sum = SUMW'(ppd_b3) + SUMW'(integ_q);
			rnd = sum + $signed({{(SUMW-Q_SHIFT){1'b0}}, {Q_SHIFT{sum[SUMW-1]}}});
			tq  = rnd >>> Q_SHIFT;
			lim = $signed(SUMW'(acfg[a].limit));
			priority if (tq > lim) begin
				sat = lim;
			end else if (tq < -lim) begin
				sat = -lim;
			end else begin
				sat = tq;
			end
		end

		// controller state; a clear zeroes it in order with the updates
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				last_q  <= '0;
				integ_q <= '0;
			end else if (adv) begin
				if (v_b1) begin
					last_q <= (cmd_b1 == CMD_CLEAR) ? '0 : err_b1;
				end
				if (v_b2) begin
					integ_q <= (cmd_b2 == CMD_CLEAR) ? '0 : INTEG_W'(acc_sat);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				err_b1   <= err_in[a];
				pi_b2    <= err_b1 * acfg[a].ki;
				pp_b2    <= err_b1 * acfg[a].kp;
				pd_b2    <= diff * acfg[a].kd;
				ppd_b3   <= (PW+2)'(pp_b2) + (PW+2)'(pd_b2);
				drive_b4 <= DRIVE_W'(sat);
			end
		end

		assign drv[a] = drive_b4;
	end

endmodule

`default_nettype wire

[rtl/pitch_roll_pid_controller_core.sv]
// An accepted update goes through front stages s1-s6, the queue and back stages b1-b4.
// Throughput: one update per cycle; front pipeline, queue and back pipeline each move one
// item per cycle, and the back stalls only while the drive register is held.
// A clear item takes the same path, zeroes integrators and last errors, and gives no result.
// Reset (arst_n low): gains, limits, integrators, last errors and all valid flags go to zero.
// Top level: register file, front end, queue and back end.
`default_nettype none

module pitch_roll_pid_controller_core #(
	parameter int RADIO_LOW       = prpid_pkg::RADIO_LOW_DEF,
	parameter int RADIO_HIGH      = prpid_pkg::RADIO_HIGH_DEF,
	parameter int PITCH_MAX_ANGLE = prpid_pkg::PITCH_MAX_ANGLE_DEF,
	parameter int ROLL_MAX_ANGLE  = prpid_pkg::ROLL_MAX_ANGLE_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	prpid_update_if.sink  update,
	prpid_drive_if.source drive,
	prpid_cfg_if.sink     cfg
);
	import prpid_pkg::*;

	localparam int MAX_ANG = (PITCH_MAX_ANGLE > ROLL_MAX_ANGLE) ? PITCH_MAX_ANGLE
		: ROLL_MAX_ANGLE;
	localparam int ERR_W   = $clog2(MEAS_DEG_MAX + MAX_ANG + 1) + 1;
	localparam int ENTRY_W = 2 * ERR_W + 1;

	axis_cfg_t pitch_cfg_q;
	axis_cfg_t roll_cfg_q;

	// register writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_cfg_q <= '0;
			roll_cfg_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PITCH_KP:    pitch_cfg_q.kp    <= $signed(cfg.data);
				REG_PITCH_KI_DT: pitch_cfg_q.ki    <= $signed(cfg.data);
				REG_PITCH_KD_DT: pitch_cfg_q.kd    <= $signed(cfg.data);
				REG_ROLL_KP:     roll_cfg_q.kp     <= $signed(cfg.data);
				REG_ROLL_KI_DT:  roll_cfg_q.ki     <= $signed(cfg.data);
				REG_ROLL_KD_DT:  roll_cfg_q.kd     <= $signed(cfg.data);
				REG_PITCH_LIMIT: pitch_cfg_q.limit <= cfg.data[LIMIT_W-1:0];
				REG_ROLL_LIMIT:  roll_cfg_q.limit  <= cfg.data[LIMIT_W-1:0];
			endcase
		end
	end

	logic                    q_push;
	logic                    q_full;
	logic                    q_pop;
	logic                    q_empty;
	logic [ENTRY_W-1:0]      q_rdata;
	logic                    f_cmd;
	logic signed [ERR_W-1:0] f_err_pitch;
	logic signed [ERR_W-1:0] f_err_roll;

	prpid_front #(
		.RADIO_LOW       (RADIO_LOW),
		.RADIO_HIGH      (RADIO_HIGH),
		.PITCH_MAX_ANGLE (PITCH_MAX_ANGLE),
		.ROLL_MAX_ANGLE  (ROLL_MAX_ANGLE),
		.ERR_W           (ERR_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.update       (update),
		.full         (q_full),
		.push         (q_push),
		.cmd_s6       (f_cmd),
		.err_pitch_s6 (f_err_pitch),
		.err_roll_s6  (f_err_roll)
	);

	prpid_queue #(
		.W     (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({f_cmd, f_err_pitch, f_err_roll}),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	prpid_back #(
		.ERR_W (ERR_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pitch_cfg (pitch_cfg_q),
		.roll_cfg  (roll_cfg_q),
		.empty     (q_empty),
		.rdata     (q_rdata),
		.pop       (q_pop),
		.drive     (drive)
	);

endmodule

`default_nettype wire

[rtl/prpid_checker.sv]
// Port-level checks of the controller core and their bind to the top level.
`default_nettype none

module prpid_checker (
	input wire logic      clk,
	input wire logic      arst_n,
	prpid_update_if.sink  update,
	prpid_drive_if.source drive,
	prpid_cfg_if.sink     cfg
);
	import prpid_pkg::*;

	// a stalled result holds its value
	a_drive_hold: assert property (@(posedge clk) disable iff (!arst_n)
		drive.valid && !drive.ready |=> drive.valid
			&& $stable(drive.pitch_drive) && $stable(drive.roll_drive))
		else $error("drive result changed while stalled");

	// saturation is symmetric, so the most negative code never shows
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		drive.valid |-> drive.pitch_drive != 16'sh8000 && drive.roll_drive != 16'sh8000)
		else $error("drive outside the symmetric limit range");

	// the input side backs up only after the output side has stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!update.ready |-> $past(drive.valid && !drive.ready))
		else $error("update stalled without an output stall");

	// register writes never wait
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid |-> cfg.ready)
		else $error("register write not taken");

endmodule

bind pitch_roll_pid_controller_core prpid_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.update (update),
	.drive  (drive),
	.cfg    (cfg)
);

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for the pitch/roll PID core: directed table, random phases, live predictor.

module testbench;
	import prpid_pkg::*;

	// Radio mapping and angle bounds of the default build
	localparam longint RADIO_LO      = 1000;
	localparam longint RADIO_HI      = 1956;
	localparam longint DEADBAND_LO   = 1460;
	localparam longint DEADBAND_HI   = 1500;
	localparam longint STICK_CENTER  = 1478;
	localparam longint PITCH_MAX_DEG = 30;
	localparam longint ROLL_MAX_DEG  = 30;

	localparam int DRAIN_CYCLES = 30;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 225;

	typedef struct packed {
		logic                     cmd;
		logic [PULSE_W-1:0]       roll_pulse;
		logic [PULSE_W-1:0]       pitch_pulse;
		logic signed [MEAS_W-1:0] meas_pitch;
		logic signed [MEAS_W-1:0] meas_roll;
	} update_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] pitch;
		logic signed [DRIVE_W-1:0] roll;
	} drive_t;

	typedef enum logic {ROW_WRITE, ROW_UPDATE} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] wdata;
		update_t               item;
		bit                    typed;
		drive_t                want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	prpid_update_if upd_bus();
	prpid_drive_if  drv_bus();
	prpid_cfg_if    cfg_bus();

	pitch_roll_pid_controller_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.update (upd_bus),
		.drive  (drv_bus),
		.cfg    (cfg_bus)
	);

	// Predictor copy of registers and controller state
	axis_cfg_t                pitch_set = '0;
	axis_cfg_t                roll_set  = '0;
	logic signed [INTEG_W-1:0] pitch_integ = '0;
	logic signed [INTEG_W-1:0] roll_integ  = '0;
	logic signed [15:0]       pitch_last  = '0;
	logic signed [15:0]       roll_last   = '0;

	drive_t    expected_drives[$];
	plan_row_t plan[$];

	int  err_count       = 0;
	int  updates_sent    = 0;
	int  clears_sent     = 0;
	int  results_checked = 0;
	int  writes_done     = 0;
	logic idle_on  = 1'b1;
	logic hold_off = 1'b0;
	bit   hold_go  = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint sym_clamp(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// Whole-degree error: measured angle minus the stick target, truncated toward zero
	function automatic longint degree_error(logic [PULSE_W-1:0] pulse,
		logic signed [MEAS_W-1:0] meas, longint max_deg);
		longint p, m, span, num;
		span = RADIO_HI - RADIO_LO;
		p = pulse;
		m = meas;
		if (p > DEADBAND_LO && p < DEADBAND_HI)
			p = STICK_CENTER;
		if (p < RADIO_LO)
			p = RADIO_LO;
		if (p > RADIO_HI)
			p = RADIO_HI;
		num = (p - RADIO_LO) * 90 - 45 * span;
		num = sym_clamp(num, max_deg * span);
		return (m * span - 256 * num) / (256 * span);
	endfunction

	// One PID axis with integrator and output saturation
	function automatic logic signed [DRIVE_W-1:0] axis_step(longint err, axis_cfg_t c,
		inout logic signed [INTEG_W-1:0] integ, inout logic signed [15:0] last);
		longint bound, acc, sum, res;
		bound = longint'(c.limit) * 256;
		acc = sym_clamp(longint'(integ) + err * longint'($signed(c.ki)), bound);
		integ = acc[INTEG_W-1:0];
		sum = longint'($signed(c.kp)) * err + acc
			+ longint'($signed(c.kd)) * (err - longint'(last));
		last = err[15:0];
		res = sym_clamp(sum / 256, longint'(c.limit));
		return res[DRIVE_W-1:0];
	endfunction

	function automatic bit predict_drive(update_t u, output drive_t d);
		longint ep, er;
		d = '0;
		if (u.cmd == CMD_CLEAR) begin
			pitch_integ = '0;
			roll_integ  = '0;
			pitch_last  = '0;
			roll_last   = '0;
			return 1'b0;
		end
		ep = degree_error(u.pitch_pulse, u.meas_pitch, PITCH_MAX_DEG);
		er = degree_error(u.roll_pulse, u.meas_roll, ROLL_MAX_DEG);
		d.pitch = axis_step(ep, pitch_set, pitch_integ, pitch_last);
		d.roll  = axis_step(er, roll_set, roll_integ, roll_last);
		return 1'b1;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_PITCH_KP:    pitch_set.kp = val;
			REG_PITCH_KI_DT: pitch_set.ki = val;
			REG_PITCH_KD_DT: pitch_set.kd = val;
			REG_ROLL_KP:     roll_set.kp  = val;
			REG_ROLL_KI_DT:  roll_set.ki  = val;
			REG_ROLL_KD_DT:  roll_set.kd  = val;
			REG_PITCH_LIMIT: pitch_set.limit = val[LIMIT_W-1:0];
			REG_ROLL_LIMIT:  roll_set.limit  = val[LIMIT_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void plan_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		plan_row_t r;
		r = '{kind: ROW_WRITE, default: '0};
		r.kind  = ROW_WRITE;
		r.idx   = idx;
		r.wdata = val;
		plan.push_back(r);
	endfunction

	function automatic void plan_update(logic cmd, int rp, int pp, int mp, int mr,
		bit typed, int wp, int wr);
		plan_row_t r;
		r = '{kind: ROW_UPDATE, default: '0};
		r.kind = ROW_UPDATE;
		r.item.cmd         = cmd;
		r.item.roll_pulse  = rp[PULSE_W-1:0];
		r.item.pitch_pulse = pp[PULSE_W-1:0];
		r.item.meas_pitch  = mp[MEAS_W-1:0];
		r.item.meas_roll   = mr[MEAS_W-1:0];
		r.typed      = typed;
		r.want.pitch = wp[DRIVE_W-1:0];
		r.want.roll  = wr[DRIVE_W-1:0];
		plan.push_back(r);
	endfunction

	// Random stimulus pieces
	function automatic logic [PULSE_W-1:0] random_pulse();
		int edges[12] = '{0, 999, 1000, 1001, 1460, 1461, 1499, 1500, 1955, 1956, 1957, 4095};
		case ($urandom_range(0, 9))
			0: return PULSE_W'($urandom_range(0, 4095));
			1: return PULSE_W'($urandom_range(1455, 1505));
			2: return PULSE_W'(edges[$urandom_range(0, 11)]);
			default: return PULSE_W'($urandom_range(1000, 1956));
		endcase
	endfunction

	function automatic logic signed [MEAS_W-1:0] random_angle();
		case ($urandom_range(0, 9))
			0: return MEAS_W'($urandom());
			1: return MEAS_W'(int'($urandom_range(0, 20480)) - 10240);
			default: return MEAS_W'(int'($urandom_range(0, 92160)) - 46080);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_gain();
		int mag;
		mag = $urandom_range(0, 1024);
		if ($urandom_range(0, 3) == 0)
			return CFG_DATA_W'($urandom());
		return ($urandom_range(0, 1) != 0) ? CFG_DATA_W'(-mag) : CFG_DATA_W'(mag);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_limit();
		case ($urandom_range(0, 4))
			0: return CFG_DATA_W'($urandom());
			1: return CFG_DATA_W'($urandom_range(1, 64));
			default: return CFG_DATA_W'($urandom_range(1, 3000));
		endcase
	endfunction

	// Phase 0: all maximum, phase 1: gains minimum, phase 2: zero limits, then random
	function automatic logic [CFG_DATA_W-1:0] phase_reg_value(logic [CFG_IDX_W-1:0] idx, int ph);
		bit lim;
		lim = (idx == REG_PITCH_LIMIT) || (idx == REG_ROLL_LIMIT);
		case (ph)
			0: return 16'h7FFF;
			1: return lim ? 16'hFFFF : 16'h8000;
			2: return lim ? 16'h0000 : random_gain();
			default: return lim ? random_limit() : random_gain();
		endcase
	endfunction

	function automatic update_t random_update();
		update_t u;
		u.cmd         = ($urandom_range(0, 24) == 0) ? CMD_CLEAR : CMD_UPDATE;
		u.roll_pulse  = random_pulse();
		u.pitch_pulse = random_pulse();
		u.meas_pitch  = random_angle();
		u.meas_roll   = random_angle();
		return u;
	endfunction

	// Register write transfer; valid is left high for back-to-back writes
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do @(negedge clk); while (!cfg_bus.ready);
		@(posedge clk);
		apply_reg(idx, val);
		writes_done++;
	endtask

	// Offer one update, with an occasional idle burst in front of it
	task automatic offer_update(update_t u, bit typed, drive_t want);
		drive_t d;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			upd_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		upd_bus.valid          <= 1'b1;
		upd_bus.command        <= u.cmd;
		upd_bus.roll_pulse     <= u.roll_pulse;
		upd_bus.pitch_pulse    <= u.pitch_pulse;
		upd_bus.measured_pitch <= u.meas_pitch;
		upd_bus.measured_roll  <= u.meas_roll;
		do @(negedge clk); while (!upd_bus.ready);
		@(posedge clk);
		if (predict_drive(u, d)) begin
			expected_drives.push_back(typed ? want : d);
			updates_sent++;
		end else begin
			clears_sent++;
		end
	endtask

	// Wait out every expected result plus the pipeline depth for trailing clears
	task automatic settle();
		upd_bus.valid <= 1'b0;
		while (expected_drives.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Result side ready: random stall bursts, plus the long hold-off
	initial begin : drive_sink
		int gap;
		gap = 0;
		drv_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n || hold_off) begin
				drv_bus.ready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				drv_bus.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(0, 7);
				drv_bus.ready <= 1'b0;
			end else begin
				drv_bus.ready <= 1'b1;
			end
		end
	end

	// Long receiver hold-off so the core fills up and blocks its input
	initial begin : long_hold
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Compare each drive transfer with the oldest expectation
	always @(negedge clk) begin : drive_check
		drive_t exp_d;
		if (arst_n && drv_bus.valid && drv_bus.ready) begin
			if (expected_drives.size() == 0) begin
				err_count++;
				$display("%0t: unexpected drive result pitch %0d roll %0d", $time,
					$signed(drv_bus.pitch_drive), $signed(drv_bus.roll_drive));
			end else begin
				exp_d = expected_drives.pop_front();
				if (drv_bus.pitch_drive !== exp_d.pitch) begin
					err_count++;
					$display("%0t: pitch_drive expected %0d, got %0d", $time,
						$signed(exp_d.pitch), $signed(drv_bus.pitch_drive));
				end
				if (drv_bus.roll_drive !== exp_d.roll) begin
					err_count++;
					$display("%0t: roll_drive expected %0d, got %0d", $time,
						$signed(exp_d.roll), $signed(drv_bus.roll_drive));
				end
			end
			results_checked++;
		end
	end

	initial begin : watchdog
		#2_500_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		bit dirty;
		dirty = 1'b0;
		arst_n = 1'b0;
		upd_bus.valid          = 1'b0;
		upd_bus.command        = CMD_UPDATE;
		upd_bus.roll_pulse     = '0;
		upd_bus.pitch_pulse    = '0;
		upd_bus.measured_pitch = '0;
		upd_bus.measured_roll  = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_PITCH_KP;
		cfg_bus.data  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero gains and limits give zero drive
		plan_update(CMD_UPDATE, 1478, 1478, 0, 0, 1, 0, 0);
		plan_update(CMD_UPDATE, 0, 4095, 65535, -65536, 1, 0, 0);
		// Unit proportional gain, wide limits: drive equals the error
		plan_write(REG_PITCH_KP, 16'd256);
		plan_write(REG_ROLL_KP, 16'd256);
		plan_write(REG_PITCH_LIMIT, 16'd32767);
		plan_write(REG_ROLL_LIMIT, 16'd32767);
		plan_update(CMD_UPDATE, 1478, 1478, 2560, -2560, 1, 10, -10);
		plan_update(CMD_UPDATE, 4095, 0, 0, 0, 1, 30, -30);
		// Dead band edges: inside snaps to center, on the edge does not
		plan_update(CMD_UPDATE, 1499, 1461, 0, 0, 1, 0, 0);
		plan_update(CMD_UPDATE, 1500, 1460, 0, 0, 1, 1, -2);
		plan_update(CMD_UPDATE, 1478, 1478, 65535, -65536, 1, 255, -256);
		plan_update(CMD_UPDATE, 0, 4095, 46080, -46080, 1, 150, -150);
		plan_update(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		plan_update(CMD_CLEAR, 4095, 4095, 65535, -1, 0, 0, 0);
		// Output saturation, and a zero limit holding the drive at zero
		plan_write(REG_PITCH_LIMIT, 16'd5);
		plan_write(REG_ROLL_LIMIT, 16'd0);
		plan_update(CMD_UPDATE, 0, 0, 0, 0, 1, 5, 0);
		// Extreme gains: integrator and derivative at full scale
		plan_write(REG_PITCH_KP, 16'h8000);
		plan_write(REG_PITCH_KI_DT, 16'h7FFF);
		plan_write(REG_PITCH_KD_DT, 16'h8000);
		plan_write(REG_ROLL_KP, 16'h7FFF);
		plan_write(REG_ROLL_KI_DT, 16'h8000);
		plan_write(REG_ROLL_KD_DT, 16'h7FFF);
		plan_write(REG_PITCH_LIMIT, 16'h7FFF);
		plan_write(REG_ROLL_LIMIT, 16'hFFFF);
		plan_update(CMD_UPDATE, 0, 4095, 65535, -65536, 0, 0, 0);
		plan_update(CMD_UPDATE, 4095, 0, -65536, 65535, 0, 0, 0);
		plan_update(CMD_UPDATE, 1478, 1478, 0, 0, 0, 0, 0);
		plan_update(CMD_UPDATE, 1000, 2048, 46080, -46080, 0, 0, 0);
		plan_update(CMD_CLEAR, 2730, 1365, 43690, 21845, 0, 0, 0);
		plan_update(CMD_UPDATE, 1957, 1956, -1, 1, 0, 0, 0);
		plan_write(REG_PITCH_LIMIT, 16'd1);
		plan_update(CMD_UPDATE, 999, 1001, 23000, -23000, 0, 0, 0);
		plan_update(CMD_UPDATE, 2730, 1365, 43690, 21845, 0, 0, 0);

		// Walk the directed table; drain before each group of writes
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				if (dirty) begin
					settle();
					dirty = 1'b0;
				end
				write_reg(plan[i].idx, plan[i].wdata);
				if (i + 1 >= plan.size() || plan[i+1].kind != ROW_WRITE)
					cfg_bus.valid <= 1'b0;
			end else begin
				offer_update(plan[i].item, plan[i].typed, plan[i].want);
				dirty = 1'b1;
			end
		end
		settle();

		// Random phases, each with fresh settings; the last one runs without idling
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == PHASES - 1)
				idle_on <= 1'b0;
			for (int k = 0; k <= int'(REG_ROLL_LIMIT); k++)
				write_reg(CFG_IDX_W'(k), phase_reg_value(CFG_IDX_W'(k), ph));
			cfg_bus.valid <= 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 3 && n == 60)
					hold_go = 1'b1;
				offer_update(random_update(), 1'b0, '0);
			end
			settle();
		end

		$display("Run covered %0d updates and %0d clears with %0d register writes;",
			updates_sent, clears_sent, writes_done);
		$display("%0d drive results compared across %0d setting phases.",
			results_checked, PHASES);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
